FILE: sv/gdfo_pkg.sv
// Shared types and constants for the depth first graph walker.
// Used by the walker, its stack memory and the testbench; depends on nothing else.
`default_nettype none

package gdfo_pkg;

   // Vertex numbers as carried on the ports and in the walk stack.
   typedef logic [4:0] vtx_type;

   // Configured vertex count register.
   typedef logic [4:0] count_type;

   // Count of vertices reported in one walk.
   typedef logic [4:0] nres_type;

   localparam int MAX_RESULTS = 16;
   localparam count_type COUNT_RESET = 5'd16;

   typedef enum logic {
      OP_ADD_EDGE = 1'b0,
      OP_RUN_WALK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_EDGE_REJECT   = 2'd1,
      STATUS_START_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_DECIDE,
      ST_POP,
      ST_END
   } state_type;

endpackage

`default_nettype wire

FILE: sv/gdfo_adj_mem.sv
// Adjacency matrix memory: one row of neighbor bits per vertex.
// One write port and one registered read port; rows read as zero until written.
`default_nettype none

module gdfo_adj_mem #(
   parameter int ROWS = 16,
   parameter int AW   = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [ROWS-1:0] wr_data,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output logic      [ROWS-1:0] rd_data
);

   logic [ROWS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [ROWS-1:0] rd_data_ff;

   // Storage array; the read returns the contents from before a same-cycle write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   // Row valid bits stand in for clearing the array at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/gdfo_stack_mem.sv
// Walk stack memory holding the vertex numbers on the current path.
// One write port and one registered read port; uses gdfo_pkg for the vertex type.
`default_nettype none

module gdfo_stack_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire gdfo_pkg::vtx_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output gdfo_pkg::vtx_type      rd_data
);

   gdfo_pkg::vtx_type mem [DEPTH];
   gdfo_pkg::vtx_type rd_data_ff;

   // Entries are only read after they have been pushed, so no reset is kept.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/graph_depth_first_order.sv
// Depth first graph walker. An accepted edge request gives its one response through the states
// CHECK, EDGE_A and EDGE_B; a rejected edge or an invalid start gives it from CHECK.
// A walk passes CHECK to the start, then takes one DECIDE step per visited vertex
// and a DECIDE and a POP step per backtrack, as the adjacency and stack memories
// have registered reads. One request is worked at a time.
// Synchronous reset empties the graph at once through row valid bits (no clearing
// pass) and sets the vertex count to 16.
`default_nettype none

module graph_depth_first_order #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [4:0] req_edge_from,
   input  wire logic [4:0] req_edge_to,
   input  wire logic [4:0] req_start_vertex,
   // Response channel.
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [4:0]      rsp_visited_vertex,
   output logic [1:0]      rsp_status,
   output logic            rsp_last,
   // Vertex count register.
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int DW = $clog2(MAX_VERTICES + 1);

   gdfo_pkg::state_type  state_ff, state_in;
   gdfo_pkg::op_type     op_ff, op_in;
   gdfo_pkg::vtx_type    from_ff, from_in;
   gdfo_pkg::vtx_type    to_ff, to_in;
   gdfo_pkg::vtx_type    start_ff, start_in;
   gdfo_pkg::count_type  count_ff;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [DW-1:0]        depth_ff, depth_in;
   gdfo_pkg::vtx_type    top_ff, top_in;
   gdfo_pkg::vtx_type    pend_ff, pend_in;
   gdfo_pkg::nres_type   nres_ff, nres_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   gdfo_pkg::vtx_type    rsp_vertex_ff, rsp_vertex_in;
   gdfo_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                    adj_wr_en, adj_rd_en;
   logic [AW-1:0]           adj_wr_addr, adj_rd_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
   logic                    stk_wr_en, stk_rd_en;
   logic [AW-1:0]           stk_wr_addr, stk_rd_addr;
   gdfo_pkg::vtx_type       stk_wr_data, stk_rd_data;

   logic [MAX_VERTICES-1:0] act_mask;
   logic [MAX_VERTICES-1:0] cand;
   logic [AW-1:0]           cand_idx;
   gdfo_pkg::vtx_type       cand_v;
   logic [DW-1:0]           depth_m2;
   logic                    out_free;
   logic                    push_ok;

   // Row index of a vertex numbered from one.
   function automatic logic [AW-1:0] vidx(gdfo_pkg::vtx_type x);
      gdfo_pkg::vtx_type xm;
      xm = x - gdfo_pkg::vtx_type'(1);
      return AW'(xm);
   endfunction

   // Bit mask with only the bit of vertex x set.
   function automatic logic [MAX_VERTICES-1:0] vbit(gdfo_pkg::vtx_type x);
      logic [MAX_VERTICES-1:0] m;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         m[i] = (int'(x) == i + 1);
      end
      return m;
   endfunction

   // A vertex is usable when it lies in one to the active count and does not exceed MAX_VERTICES.
   function automatic logic vok(gdfo_pkg::vtx_type x, gdfo_pkg::count_type c);
      return (x != '0) && (int'(x) <= MAX_VERTICES) && (x <= c);
   endfunction

   gdfo_adj_mem #(
      .ROWS (MAX_VERTICES),
      .AW   (AW)
   ) u_adj (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   gdfo_stack_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Vertex count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= gdfo_pkg::COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // Vertices above the active count are ignored by the walk.
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         act_mask[i] = (i < int'(count_ff));
      end
   end

   // Lowest-numbered unvisited neighbor of the top vertex.
   always_comb begin
      cand     = adj_rd_data & ~visited_ff & act_mask;
      cand_idx = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            cand_idx = AW'(i);
         end
      end
      cand_v = gdfo_pkg::vtx_type'(cand_idx) + gdfo_pkg::vtx_type'(1);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign depth_m2 = depth_ff - DW'(2);
   assign push_ok  = int'(depth_ff) < MAX_VERTICES;

   // Sequencer: next state, memory accesses and response generation.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      start_in      = start_ff;
      visited_in    = visited_ff;
      depth_in      = depth_ff;
      top_in        = top_ff;
      pend_in       = pend_ff;
      nres_in       = nres_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      adj_wr_en     = 1'b0;
      adj_wr_addr   = '0;
      adj_wr_data   = '0;
      adj_rd_en     = 1'b0;
      adj_rd_addr   = '0;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = '0;
      stk_wr_data   = '0;
      stk_rd_en     = 1'b0;
      stk_rd_addr   = '0;

      case (state_ff)
         gdfo_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = gdfo_pkg::op_type'(req_operation);
               from_in  = req_edge_from;
               to_in    = req_edge_to;
               start_in = req_start_vertex;
               state_in = gdfo_pkg::ST_CHECK;
            end
         end

         gdfo_pkg::ST_CHECK: begin
            if (op_ff == gdfo_pkg::OP_ADD_EDGE) begin
               if (!(vok(from_ff, count_ff) && vok(to_ff, count_ff))) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_vertex_in = '0;
                     rsp_status_in = gdfo_pkg::STATUS_EDGE_REJECT;
                     rsp_last_in   = 1'b1;
                     state_in      = gdfo_pkg::ST_IDLE;
                  end
               end else begin
                  adj_rd_en   = 1'b1;
                  adj_rd_addr = vidx(from_ff);
                  state_in    = gdfo_pkg::ST_EDGE_A;
               end
            end else if (!vok(start_ff, count_ff)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_vertex_in = '0;
                  rsp_status_in = gdfo_pkg::STATUS_START_INVALID;
                  rsp_last_in   = 1'b1;
                  state_in      = gdfo_pkg::ST_IDLE;
               end
            end else begin
               // Start the walk: the start vertex is the first entry of the order.
               visited_in  = vbit(start_ff);
               stk_wr_en   = 1'b1;
               stk_wr_addr = '0;
               stk_wr_data = start_ff;
               depth_in    = DW'(1);
               top_in      = start_ff;
               pend_in     = start_ff;
               nres_in     = gdfo_pkg::nres_type'(1);
               adj_rd_en   = 1'b1;
               adj_rd_addr = vidx(start_ff);
               state_in    = gdfo_pkg::ST_DECIDE;
            end
         end

         gdfo_pkg::ST_EDGE_A: begin
            // A self loop reads back the old row here, which gives the same write.
            adj_wr_en   = 1'b1;
            adj_wr_addr = vidx(from_ff);
            adj_wr_data = adj_rd_data | vbit(to_ff);
            adj_rd_en   = 1'b1;
            adj_rd_addr = vidx(to_ff);
            state_in    = gdfo_pkg::ST_EDGE_B;
         end

         gdfo_pkg::ST_EDGE_B: begin
            if (out_free) begin
               adj_wr_en     = 1'b1;
               adj_wr_addr   = vidx(to_ff);
               adj_wr_data   = adj_rd_data | vbit(from_ff);
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_status_in = gdfo_pkg::STATUS_OK;
               rsp_last_in   = 1'b1;
               state_in      = gdfo_pkg::ST_IDLE;
            end
         end

         gdfo_pkg::ST_DECIDE: begin
            if (cand == '0) begin
               // Backtrack; fetch the new top from the stack unless it is empty.
               depth_in = depth_ff - DW'(1);
               if (depth_ff == DW'(1)) begin
                  state_in = gdfo_pkg::ST_END;
               end else begin
                  stk_rd_en   = 1'b1;
                  stk_rd_addr = depth_m2[AW-1:0];
                  state_in    = gdfo_pkg::ST_POP;
               end
            end else if (out_free) begin
               // The held vertex is not the last one, so it goes out now.
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_status_in = gdfo_pkg::STATUS_OK;
               rsp_last_in   = 1'b0;
               pend_in       = cand_v;
               visited_in    = visited_ff | vbit(cand_v);
               nres_in       = nres_ff + gdfo_pkg::nres_type'(1);
               adj_rd_en     = 1'b1;
               adj_rd_addr   = vidx(top_ff);
               if (push_ok) begin
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = depth_ff[AW-1:0];
                  stk_wr_data = cand_v;
                  depth_in    = depth_ff + DW'(1);
                  top_in      = cand_v;
                  adj_rd_addr = vidx(cand_v);
               end
               if (nres_in == gdfo_pkg::nres_type'(gdfo_pkg::MAX_RESULTS)) begin
                  state_in = gdfo_pkg::ST_END;
               end
            end
         end

         gdfo_pkg::ST_POP: begin
            top_in      = stk_rd_data;
            adj_rd_en   = 1'b1;
            adj_rd_addr = vidx(stk_rd_data);
            state_in    = gdfo_pkg::ST_DECIDE;
         end

         gdfo_pkg::ST_END: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_status_in = gdfo_pkg::STATUS_OK;
               rsp_last_in   = 1'b1;
               state_in      = gdfo_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gdfo_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdfo_pkg::ST_IDLE;
         visited_ff   <= '0;
         depth_ff     <= '0;
         nres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         nres_ff      <= nres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      start_ff      <= start_in;
      top_ff        <= top_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall          = (state_ff != gdfo_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // The stack never holds more entries than there are vertices.
   a_depth_bound : assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= MAX_VERTICES)
      else $error("walk stack depth exceeds its size");

   // A step is only taken with a vertex on the stack.
   a_decide_depth : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfo_pkg::ST_DECIDE) |-> (depth_ff != '0))
      else $error("walk step with an empty stack");

   // During a walk only active vertices are marked visited.
   a_visited_active : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfo_pkg::ST_DECIDE || state_ff == gdfo_pkg::ST_POP)
      |-> ((visited_ff & ~act_mask) == '0))
      else $error("inactive vertex marked visited");

   // A walk reports no more than the result limit.
   a_result_bound : assert property (@(posedge clock) disable iff (reset)
      int'(nres_ff) <= gdfo_pkg::MAX_RESULTS)
      else $error("walk reported too many vertices");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/gdfo_order_checker.sv
// Checker for the depth first graph walker: watches the request, response and
// register ports, predicts the visit order of each request and compares it.
// Depends on gdfo_pkg for the vertex and count types, operation codes and status codes.

module gdfo_order_checker #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic       req_operation,
   input  wire logic [4:0] req_edge_from,
   input  wire logic [4:0] req_edge_to,
   input  wire logic [4:0] req_start_vertex,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [4:0] rsp_visited_vertex,
   input  wire logic [1:0] rsp_status,
   input  wire logic       rsp_last,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data,
   output int              mismatch_count,
   output int              outstanding_count
);

   // One response as the block should present it.
   typedef struct packed {
      gdfo_pkg::vtx_type    vertex;
      gdfo_pkg::status_type status;
      logic                 last;
   } visit_type;

   // Private copy of the graph, the walk state and the vertex count.
   logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] visited;
   int                      walk_path [MAX_VERTICES];
   int                      walk_depth;
   gdfo_pkg::count_type     vertex_count;
   visit_type               expected_visits [$];

   task automatic report_mismatch(input string message);
      $display("mismatch at %0t: %s", $time, message);
      mismatch_count++;
   endtask

   // Works out the responses of one accepted request and updates the graph.
   task automatic compute_visit_order(input gdfo_pkg::op_type op, input int from_v,
                                      input int to_v, input int start);
      int                      active;
      int                      emitted;
      int                      top;
      int                      next;
      logic [MAX_VERTICES-1:0] reachable;
      logic [MAX_VERTICES-1:0] in_use;
      visit_type               held;
      active = (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
      in_use = '0;
      for (int i = 0; i < active; i++) begin
         in_use[i] = 1'b1;
      end
      if (op == gdfo_pkg::OP_ADD_EDGE) begin
         // An edge with either endpoint outside the active range is dropped whole.
         if (from_v < 1 || from_v > active || to_v < 1 || to_v > active) begin
            expected_visits.push_back('{vertex: '0,
                                        status: gdfo_pkg::STATUS_EDGE_REJECT,
                                        last: 1'b1});
         end else begin
            adjacency[from_v - 1][to_v - 1] = 1'b1;
            adjacency[to_v - 1][from_v - 1] = 1'b1;
            expected_visits.push_back('{vertex: '0, status: gdfo_pkg::STATUS_OK,
                                        last: 1'b1});
         end
      end else if (start < 1 || start > active) begin
         expected_visits.push_back('{vertex: '0, status: gdfo_pkg::STATUS_START_INVALID,
                                     last: 1'b1});
      end else begin
         // Depth first walk; each visit is held back until we know whether it is the last.
         visited = '0;
         visited[start - 1] = 1'b1;
         walk_path[0] = start;
         walk_depth = 1;
         held = '{vertex: gdfo_pkg::vtx_type'(start), status: gdfo_pkg::STATUS_OK,
                  last: 1'b0};
         emitted = 1;
         while (walk_depth > 0 && emitted < gdfo_pkg::MAX_RESULTS) begin
            top = walk_path[(walk_depth - 1) % MAX_VERTICES];
            reachable = '0;
            if (top >= 1 && top <= MAX_VERTICES) begin
               reachable = adjacency[top - 1] & ~visited & in_use;
            end
            if (reachable == '0) begin
               walk_depth--;
            end else begin
               next = 0;
               while (!reachable[next]) begin
                  next++;
               end
               visited[next] = 1'b1;
               if (walk_depth < MAX_VERTICES) begin
                  walk_path[walk_depth] = next + 1;
                  walk_depth++;
               end
               expected_visits.push_back(held);
               held = '{vertex: gdfo_pkg::vtx_type'(next + 1), status: gdfo_pkg::STATUS_OK,
                        last: 1'b0};
               emitted++;
            end
         end
         held.last = 1'b1;
         expected_visits.push_back(held);
      end
   endtask

   // Responses are checked before new requests are predicted, since a response
   // always belongs to a request accepted at an earlier edge.
   always @(posedge clock) begin : monitor
      visit_type want;
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adjacency[i] = '0;
         end
         visited = '0;
         walk_depth = 0;
         vertex_count = gdfo_pkg::COUNT_RESET;
         expected_visits.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_visits.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding, vertex %0d",
                                         rsp_visited_vertex));
            end else begin
               want = expected_visits.pop_front();
               if (rsp_visited_vertex !== want.vertex) begin
                  report_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                            rsp_visited_vertex, want.vertex));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
               end
            end
         end
         if (csr_write_enable) begin
            vertex_count = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            compute_visit_order(gdfo_pkg::op_type'(req_operation), int'(req_edge_from),
                                int'(req_edge_to), int'(req_start_vertex));
         end
      end
      outstanding_count = expected_visits.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the testbench for the depth first graph walker: clock, reset, requests,
// register writes, response stalls and the verdict.
// Depends on gdfo_pkg, graph_depth_first_order and gdfo_order_checker.

module tb_top;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 60;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int PHASE_TOTAL     = 8;
   localparam int PHASE_COUNTS [PHASE_TOTAL] = '{16, 4, 1, 10, 20, 7, 13, 16};

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_operation      = 1'b0;
   logic [4:0] req_edge_from      = '0;
   logic [4:0] req_edge_to        = '0;
   logic [4:0] req_start_vertex   = '0;
   logic       rsp_stall          = 1'b0;
   logic       csr_write_enable   = 1'b0;
   logic [4:0] csr_write_data     = '0;
   logic       req_stall;
   logic       rsp_valid;
   logic [4:0] rsp_visited_vertex;
   logic [1:0] rsp_status;
   logic       rsp_last;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;
   int mismatch_count;
   int outstanding_count;

   graph_depth_first_order u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .req_start_vertex   (req_start_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   gdfo_order_checker u_order_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .req_start_vertex   (req_start_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .outstanding_count  (outstanding_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The response side stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Presents one request, after an optional random gap, and waits until it is taken.
   task automatic send_request(input gdfo_pkg::op_type op, input gdfo_pkg::vtx_type from_v,
                               input gdfo_pkg::vtx_type to_v,
                               input gdfo_pkg::vtx_type start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_edge_from    <= from_v;
      req_edge_to      <= to_v;
      req_start_vertex <= start;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic add_edge(input int from_v, input int to_v);
      send_request(gdfo_pkg::OP_ADD_EDGE, gdfo_pkg::vtx_type'(from_v),
                   gdfo_pkg::vtx_type'(to_v), gdfo_pkg::vtx_type'($urandom_range(31)));
   endtask

   task automatic run_walk(input int start);
      send_request(gdfo_pkg::OP_RUN_WALK, gdfo_pkg::vtx_type'($urandom_range(31)),
                   gdfo_pkg::vtx_type'($urandom_range(31)), gdfo_pkg::vtx_type'(start));
   endtask

   // Stops sending and waits until every response has come and the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_vertex_count(input int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= gdfo_pkg::count_type'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed edges and walks inside the active range, some pure noise.
   // Half of the edges join near neighbors so that walks run deep before backtracking.
   task automatic random_request(input int active);
      int roll;
      int from_v;
      int to_v;
      roll   = $urandom_range(99);
      from_v = $urandom_range(active, 1);
      to_v   = $urandom_range(active, 1);
      if ($urandom_range(1) == 1) begin
         to_v = from_v + int'($urandom_range(6)) - 3;
         if (to_v < 1 || to_v > active) begin
            to_v = $urandom_range(active, 1);
         end
      end
      if (roll < 30) begin
         add_edge(from_v, to_v);
      end else if (roll < 85) begin
         run_walk($urandom_range(active, 1));
      end else begin
         send_request(gdfo_pkg::op_type'(1'($urandom_range(1))),
                      gdfo_pkg::vtx_type'($urandom_range(31)),
                      gdfo_pkg::vtx_type'($urandom_range(31)),
                      gdfo_pkg::vtx_type'($urandom_range(31)));
      end
   endtask

   initial begin : stimulus
      int active;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset count of 16: invalid starts and edges, a self
      // loop, a repeated edge, and walks that backtrack.
      run_walk(1);
      run_walk(0);
      run_walk(17);
      run_walk(31);
      add_edge(0, 1);
      add_edge(1, 17);
      add_edge(31, 31);
      add_edge(16, 16);
      add_edge(1, 2);
      add_edge(2, 3);
      add_edge(2, 1);
      add_edge(16, 15);
      add_edge(1, 5);
      run_walk(1);
      run_walk(16);
      run_walk(3);

      // Shrunk count: vertex 3 is ignored by the walk and rejected as an endpoint.
      set_vertex_count(2);
      run_walk(1);
      run_walk(3);
      add_edge(3, 1);

      // A count of zero leaves no vertex valid.
      set_vertex_count(0);
      add_edge(1, 1);
      run_walk(1);

      // A count above the vertex limit acts as the limit.
      set_vertex_count(31);
      run_walk(16);
      run_walk(5);

      // Random phases, each at the count of its table entry and one of four idling patterns.
      for (int phase = 0; phase < PHASE_TOTAL; phase++) begin
         set_vertex_count(PHASE_COUNTS[phase]);
         active = (PHASE_COUNTS[phase] > 16) ? 16 : PHASE_COUNTS[phase];
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 45;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 45;
            end
            default: begin
               sender_idle_pct    = 10;
               receiver_stall_pct = 10;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_request(active);
      end

      // Let everything outstanding come back, then watch a while for strays.
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding_count != 0);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
